// ----- rtl/wrs_pkg.sv -----
// Shared constants, types and a helper function of the work range splitter.
`timescale 1ns / 1ps

package wrs_pkg;

    // Part count limit and the width that holds any count up to it.
    localparam int MAX_PARTS = 64;
    localparam int COUNT_W   = $clog2(MAX_PARTS + 1);

    // Field widths.
    localparam int OP_W        = 2;
    localparam int POS_W       = 16;
    localparam int START_W     = POS_W + 1;
    localparam int REQ_PARTS_W = 7;
    localparam int MAX_SIZE_W  = 24;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MAX_SIZE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_PARTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE  = 2'd1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_COLUMN = 2'd0;
    localparam logic [OP_W-1:0] OP_RENDER = 2'd1;
    localparam logic [OP_W-1:0] OP_ROW    = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // Serial divider.
    localparam int DIV_W     = MAX_SIZE_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Command queue between the planner and the emitter.
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_FILL_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIV_W-1:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_W-1:0]     quotient;
        logic [DIV_W-1:0]     remainder;
    } t_div_rsp;

    // One planned request, ready to be emitted as parts.
    typedef struct packed {
        logic [OP_W-1:0]      opcode;
        logic [POS_W-1:0]     origin;
        logic [POS_W-1:0]     extent;
        logic [COUNT_W-1:0]   count;
        logic [POS_W-1:0]     chunk;
    } t_cmd;

    // Caps a raw part count at the extent (split modes) and at MAX_PARTS.
    function automatic logic [COUNT_W-1:0] clamp_count(
        input logic [OP_W-1:0]  op,
        input logic [POS_W:0]   n_raw,
        input logic [POS_W-1:0] extent
    );
        logic [POS_W:0] n;
        n = n_raw;
        if (op != OP_RENDER && n > {1'b0, extent}) begin
            n = {1'b0, extent};
        end
        if (n > (POS_W + 1)'(MAX_PARTS)) begin
            n = (POS_W + 1)'(MAX_PARTS);
        end
        return n[COUNT_W-1:0];
    endfunction

endpackage

// ----- rtl/wrs_if.sv -----
// Channel interfaces of the work range splitter: request, part and configuration.
`timescale 1ns / 1ps

interface wrs_req_if;
    logic                           valid;
    logic                           ready;
    logic [wrs_pkg::OP_W-1:0]       opcode;
    logic [wrs_pkg::POS_W-1:0]      origin;
    logic [wrs_pkg::POS_W-1:0]      extent;
    logic [wrs_pkg::POS_W-1:0]      row_width;

    modport source(output valid, output opcode, output origin, output extent,
                   output row_width, input ready);
    modport sink(input valid, input opcode, input origin, input extent,
                 input row_width, output ready);
endinterface

interface wrs_part_if;
    logic                           valid;
    logic                           ready;
    logic [wrs_pkg::START_W-1:0]    part_start;
    logic [wrs_pkg::POS_W-1:0]      part_length;
    logic                           last_part;

    modport source(output valid, output part_start, output part_length,
                   output last_part, input ready);
    modport sink(input valid, input part_start, input part_length,
                 input last_part, output ready);
endinterface

interface wrs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [wrs_pkg::CFG_IDX_W-1:0]  index;
    logic [wrs_pkg::CFG_DATA_W-1:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/wrs_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module wrs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wrs_pkg::t_div_req i_req,
    output wrs_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [wrs_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [wrs_pkg::DIV_W-1:0]     r_quo;
    logic [wrs_pkg::DIV_W-1:0]     r_rem;
    logic [wrs_pkg::DIV_W-1:0]     r_dsr;

    logic [wrs_pkg::DIV_W:0]       shifted;
    logic [wrs_pkg::DIV_W:0]       diff;
    logic                          fits;

    // The dividend shifts out of the top of r_quo while quotient bits enter at the bottom.
    always_comb begin
        shifted = {r_rem, r_quo[wrs_pkg::DIV_W-1]};
        diff    = shifted - {1'b0, r_dsr};
        fits    = ~diff[wrs_pkg::DIV_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= wrs_pkg::DIV_CNT_W'(wrs_pkg::DIV_W - 1);
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dsr  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[wrs_pkg::DIV_W-2:0], fits};
                r_rem <= fits ? diff[wrs_pkg::DIV_W-1:0] : shifted[wrs_pkg::DIV_W-1:0];
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// ----- rtl/wrs_front.sv -----
// Request planner: holds configuration, classifies a request and works out count and chunk.
`timescale 1ns / 1ps

module wrs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wrs_cfg_if.sink           i_cfg,
    wrs_req_if.sink           i_req,
    output wrs_pkg::t_div_req o_div,
    input  wrs_pkg::t_div_rsp i_div,
    output wrs_pkg::t_cmd     o_cmd,
    output logic              o_push,
    input  logic              i_full
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PLAN = 6'b000010,
        S_DMS  = 6'b000100,
        S_DCNT = 6'b001000,
        S_DCHK = 6'b010000,
        S_PUSH = 6'b100000
    } t_state;

    t_state                              r_state, n_state;
    logic [wrs_pkg::REQ_PARTS_W-1:0]     r_req_parts;
    logic [wrs_pkg::MAX_SIZE_W-1:0]      r_max_size;
    logic [wrs_pkg::OP_W-1:0]            r_op;
    logic [wrs_pkg::POS_W-1:0]           r_origin;
    logic [wrs_pkg::POS_W-1:0]           r_extent;
    logic [wrs_pkg::POS_W-1:0]           r_row_width;
    logic [wrs_pkg::COUNT_W-1:0]         r_count, n_count;
    logic [wrs_pkg::POS_W-1:0]           r_chunk, n_chunk;

    logic                                drop;
    logic [wrs_pkg::DIV_W-1:0]           row_div;
    logic [wrs_pkg::DIV_W-1:0]           ms_eff;
    logic [wrs_pkg::POS_W:0]             by_size;
    logic [wrs_pkg::POS_W:0]             raw_count;
    logic [wrs_pkg::POS_W:0]             req_ext;
    logic [wrs_pkg::COUNT_W-1:0]         cnt_sized;
    logic [wrs_pkg::COUNT_W-1:0]         cnt_plain;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        drop      = (r_op == wrs_pkg::OP_NONE) || (r_extent == '0);
        row_div   = (r_row_width == '0) ? wrs_pkg::DIV_W'(1)
                                        : wrs_pkg::DIV_W'(r_row_width);
        ms_eff    = (i_div.quotient == '0) ? wrs_pkg::DIV_W'(1) : i_div.quotient;
        req_ext   = (wrs_pkg::POS_W + 1)'(r_req_parts);
        by_size   = {1'b0, i_div.quotient[wrs_pkg::POS_W-1:0]}
                  + (wrs_pkg::POS_W + 1)'(i_div.remainder != '0);
        raw_count = (by_size > req_ext) ? by_size : req_ext;
        cnt_sized = wrs_pkg::clamp_count(r_op, raw_count, r_extent);
        cnt_plain = wrs_pkg::clamp_count(r_op, req_ext, r_extent);
    end

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_chunk        = r_chunk;
        o_div.start    = 1'b0;
        o_div.dividend = wrs_pkg::DIV_W'(r_extent);
        o_div.divisor  = wrs_pkg::DIV_W'(1);
        o_push         = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                if (drop) begin
                    n_state = S_IDLE;
                end else if (r_max_size == '0) begin
                    // No size limit: the requested count stands, subject to the caps.
                    n_count = cnt_plain;
                    if (cnt_plain == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        o_div.start   = 1'b1;
                        o_div.divisor = wrs_pkg::DIV_W'(cnt_plain);
                        n_state       = S_DCHK;
                    end
                end else if (r_op == wrs_pkg::OP_COLUMN) begin
                    o_div.start   = 1'b1;
                    o_div.divisor = r_max_size;
                    n_state       = S_DCNT;
                end else begin
                    o_div.start    = 1'b1;
                    o_div.dividend = r_max_size;
                    o_div.divisor  = row_div;
                    n_state        = S_DMS;
                end
            end
            S_DMS: begin
                if (i_div.done) begin
                    o_div.start   = 1'b1;
                    o_div.divisor = ms_eff;
                    n_state       = S_DCNT;
                end
            end
            S_DCNT: begin
                if (i_div.done) begin
                    // The ceiling of extent over size is the quotient plus one on a remainder.
                    n_count = cnt_sized;
                    if (cnt_sized == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        o_div.start   = 1'b1;
                        o_div.divisor = wrs_pkg::DIV_W'(cnt_sized);
                        n_state       = S_DCHK;
                    end
                end
            end
            S_DCHK: begin
                if (i_div.done) begin
                    n_chunk = i_div.quotient[wrs_pkg::POS_W-1:0];
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd.opcode = r_op;
    assign o_cmd.origin = r_origin;
    assign o_cmd.extent = r_extent;
    assign o_cmd.count  = r_count;
    assign o_cmd.chunk  = r_chunk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req_parts <= wrs_pkg::REQ_PARTS_W'(1);
            r_max_size  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    wrs_pkg::CFG_REQ_PARTS: begin
                        r_req_parts <= i_cfg.data[wrs_pkg::REQ_PARTS_W-1:0];
                    end
                    wrs_pkg::CFG_MAX_SIZE: begin
                        r_max_size <= i_cfg.data[wrs_pkg::MAX_SIZE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= n_count;
        r_chunk <= n_chunk;
        if (i_req.valid && i_req.ready) begin
            r_op        <= i_req.opcode;
            r_origin    <= i_req.origin;
            r_extent    <= i_req.extent;
            r_row_width <= i_req.row_width;
        end
    end

endmodule

// ----- rtl/wrs_fifo.sv -----
// Short command queue between the planner and the part emitter.
`timescale 1ns / 1ps

module wrs_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wrs_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output wrs_pkg::t_cmd o_head,
    output logic          o_empty
);

    wrs_pkg::t_cmd                      r_mem [wrs_pkg::QUEUE_DEPTH];
    logic [wrs_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr;
    logic [wrs_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr;
    logic [wrs_pkg::QUEUE_FILL_W-1:0]   r_fill;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_fill == wrs_pkg::QUEUE_FILL_W'(wrs_pkg::QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/wrs_back.sv -----
// Part emitter: walks a planned command and drives one part beat per cycle while the output is not stalled.
`timescale 1ns / 1ps

module wrs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wrs_pkg::t_cmd i_head,
    input  logic          i_empty,
    output logic          o_pop,
    wrs_part_if.source    o_part
);

    logic                            r_busy;
    wrs_pkg::t_cmd                   r_cmd;
    logic [wrs_pkg::COUNT_W-1:0]     r_idx;
    logic [wrs_pkg::START_W-1:0]     r_pos;
    logic [wrs_pkg::POS_W-1:0]       r_left;

    logic                            r_out_valid;
    logic [wrs_pkg::START_W-1:0]     r_out_start;
    logic [wrs_pkg::POS_W-1:0]       r_out_len;
    logic                            r_out_last;

    logic                            slot_free;
    logic                            emit;
    logic                            last;
    logic                            render;

    assign o_pop     = !r_busy && !i_empty;
    assign slot_free = !r_out_valid || o_part.ready;
    assign emit      = r_busy && slot_free;
    assign last      = (r_idx == r_cmd.count - 1'b1);
    assign render    = (r_cmd.opcode == wrs_pkg::OP_RENDER);

    assign o_part.valid       = r_out_valid;
    assign o_part.part_start  = r_out_start;
    assign o_part.part_length = r_out_len;
    assign o_part.last_part   = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cmd  <= i_head;
                r_idx  <= '0;
                r_pos  <= {1'b0, i_head.origin};
                r_left <= i_head.extent;
            end else if (emit) begin
                // The last part takes what is left, which includes the remainder.
                r_out_valid <= 1'b1;
                r_out_start <= render ? {1'b0, r_cmd.origin} : r_pos;
                r_out_len   <= render ? r_cmd.extent : (last ? r_left : r_cmd.chunk);
                r_out_last  <= last;
                r_pos       <= r_pos + {1'b0, r_cmd.chunk};
                r_left      <= r_left - r_cmd.chunk;
                r_idx       <= r_idx + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
            if (!emit && o_part.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/work_range_splitter.sv -----
// Top level of the work range splitter: planner, command queue and part emitter.
//
//   Channel   Dir   Beat                                    Accepted when
//   i_cfg     in    index, data (register write)            valid && ready (ready always high)
//   i_req     in    opcode, origin, extent, row_width       valid && ready
//   o_part    out   part_start, part_length, last_part      valid && ready
//
// The planner works out each request with serial divisions, each of which loads its
// operands and then produces 24 quotient bits; a row or render request with a size limit
// runs three of them (size by row width, count, chunk).
// The emitter then drives one part beat per cycle while the output is not stalled, up to 64 per request.
// A two-entry command queue lets the planner work on the next request while parts still flow.
// Reset is synchronous and active low; the configuration resets to one part and no size limit.
// A stalled output holds its beat; the emitter and then the queue back up behind it.
`timescale 1ns / 1ps

module work_range_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wrs_cfg_if.sink     i_cfg,
    wrs_req_if.sink     i_req,
    wrs_part_if.source  o_part
);

    wrs_pkg::t_div_req div_req;
    wrs_pkg::t_div_rsp div_rsp;
    wrs_pkg::t_cmd     push_cmd;
    wrs_pkg::t_cmd     head_cmd;
    logic              push;
    logic              full;
    logic              pop;
    logic              empty;

    wrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_req   (i_req),
        .o_div   (div_req),
        .i_div   (div_rsp),
        .o_cmd   (push_cmd),
        .o_push  (push),
        .i_full  (full)
    );

    wrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    wrs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (empty)
    );

    wrs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_part  (o_part)
    );

endmodule

// ----- bench/wrs_split_check.sv -----
// Checker for the work range splitter: predicts the part beats of each request and compares.
`timescale 1ns / 1ps

module wrs_split_check
    import wrs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    wrs_cfg_if   i_cfg,
    wrs_req_if   i_req,
    wrs_part_if  i_part,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [POS_W-1:0]   length;
        logic               last;
    } t_part_beat;

    logic [REQ_PARTS_W-1:0] req_parts;
    logic [MAX_SIZE_W-1:0]  size_limit;
    t_part_beat             part_queue[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        req_parts    = 7'd1;
        size_limit   = '0;
    end

    // Works out the parts of one request and queues them in order.
    task automatic split_request(
        input logic [OP_W-1:0]  op,
        input logic [POS_W-1:0] origin,
        input logic [POS_W-1:0] extent,
        input logic [POS_W-1:0] row_width
    );
        logic [MAX_SIZE_W-1:0] size_cap;
        logic [MAX_SIZE_W-1:0] row_div;
        logic [MAX_SIZE_W:0]   by_size;
        logic [MAX_SIZE_W:0]   count;
        logic [POS_W-1:0]      chunk;
        t_part_beat            beat;
        int unsigned           offset;

        if (op == OP_NONE || extent == '0) begin
            return;
        end
        count    = (MAX_SIZE_W + 1)'(req_parts);
        size_cap = size_limit;
        if (size_cap != '0) begin
            // Row and render modes scale the size limit down to whole rows.
            if (op != OP_COLUMN) begin
                row_div  = (row_width == '0) ? 24'd1 : 24'(row_width);
                size_cap = size_cap / row_div;
                if (size_cap == '0) begin
                    size_cap = 24'd1;
                end
            end
            by_size = ((MAX_SIZE_W + 1)'(extent) + (MAX_SIZE_W + 1)'(size_cap) - 1'b1)
                      / (MAX_SIZE_W + 1)'(size_cap);
            if (by_size > count) begin
                count = by_size;
            end
        end
        if (op != OP_RENDER && count > (MAX_SIZE_W + 1)'(extent)) begin
            count = (MAX_SIZE_W + 1)'(extent);
        end
        if (count > (MAX_SIZE_W + 1)'(MAX_PARTS)) begin
            count = (MAX_SIZE_W + 1)'(MAX_PARTS);
        end
        if (count == '0) begin
            return;
        end
        chunk = POS_W'((MAX_SIZE_W + 1)'(extent) / count);
        for (int i = 0; i < int'(count); i++) begin
            beat.last = (i == int'(count) - 1);
            if (op == OP_RENDER) begin
                beat.start  = START_W'(origin);
                beat.length = extent;
            end else begin
                offset      = int'(chunk) * i;
                beat.start  = START_W'(int'(origin) + offset);
                beat.length = beat.last ? POS_W'(int'(extent) - offset) : chunk;
            end
            part_queue = {part_queue, beat};
        end
    endtask

    always @(posedge i_clk) begin
        t_part_beat want;
        t_part_beat got;

        if (!i_rst_n) begin
            req_parts  = 7'd1;
            size_limit = '0;
            part_queue.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_REQ_PARTS) begin
                    req_parts = i_cfg.data[REQ_PARTS_W-1:0];
                end else if (i_cfg.index == CFG_MAX_SIZE) begin
                    size_limit = i_cfg.data;
                end
            end
            // Compare before queuing new work, so a stray beat never matches a fresh request.
            if (i_part.valid && i_part.ready) begin
                got = '{i_part.part_start, i_part.part_length, i_part.last_part};
                if (part_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t: unexpected part beat start=%0d length=%0d last=%0d",
                                 $realtime, got.start, got.length, got.last);
                    end
                end else begin
                    want = part_queue.pop_front();
                    if (got.start !== want.start || got.length !== want.length ||
                        got.last !== want.last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: part mismatch", $realtime);
                            $display("  expected start=%0d length=%0d last=%0d",
                                     want.start, want.length, want.last);
                            $display("  got      start=%0d length=%0d last=%0d",
                                     got.start, got.length, got.last);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                split_request(i_req.opcode, i_req.origin, i_req.extent, i_req.row_width);
            end
        end
        o_pending = part_queue.size();
    end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top of the work range splitter: clock, reset, stimulus, back pressure and verdict.
`timescale 1ns / 1ps

module tb_top;
    import wrs_pkg::*;

    localparam int HOLD_OFF   = 200;
    localparam int IDLE_LIMIT = 3000;
    localparam int PHASES     = 8;
    localparam int PHASE_REQS = 45;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic clk;
    logic rst_n;
    bit   steady;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   stall_left;

    wrs_cfg_if  cfg_ch();
    wrs_req_if  req_ch();
    wrs_part_if part_ch();

    work_range_splitter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_part  (part_ch)
    );

    wrs_split_check u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_ch),
        .i_req        (req_ch),
        .i_part       (part_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Output back pressure.
    initial begin
        part_ch.ready = 1'b0;
        stall_left    = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                part_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                part_ch.ready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 20) begin
                    stall_left = rand_gap();
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (cfg_ch.valid && cfg_ch.ready) || (req_ch.valid && req_ch.ready) ||
            (part_ch.valid && part_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_req(
        input logic [OP_W-1:0]  op,
        input logic [POS_W-1:0] origin,
        input logic [POS_W-1:0] extent,
        input logic [POS_W-1:0] row_width
    );
        int gap;
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.origin    <= origin;
        req_ch.extent    <= extent;
        req_ch.row_width <= row_width;
        do @(posedge clk); while (!req_ch.ready);
        gap = steady ? 0 : rand_gap();
        if (gap > 0) begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stops sending and waits for every expected part, then lets the planner go quiet.
    task automatic drain(input int hold);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (hold) @(negedge clk);
    endtask

    task automatic set_config(input logic [REQ_PARTS_W-1:0] parts,
                              input logic [MAX_SIZE_W-1:0] size,
                              input bit junk_bits);
        logic [CFG_DATA_W-1:0] data;
        drain(HOLD_OFF);
        data = {CFG_DATA_W{1'b0}};
        if (junk_bits) begin
            data = CFG_DATA_W'($urandom);
        end
        data[REQ_PARTS_W-1:0] = parts;
        write_reg(CFG_REQ_PARTS, data);
        write_reg(CFG_MAX_SIZE, size);
    endtask

    task automatic random_req();
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] origin;
        logic [POS_W-1:0] extent;
        logic [POS_W-1:0] row_width;
        int               r;

        op     = ($urandom_range(0, 99) < 4) ? OP_NONE : OP_W'($urandom_range(0, 2));
        origin = ($urandom_range(0, 99) < 8) ? 16'hFFFF : POS_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 5) begin
            extent = '0;
        end else if (r < 70) begin
            extent = POS_W'($urandom_range(1, 64));
        end else if (r < 88) begin
            extent = POS_W'($urandom_range(65, 2000));
        end else if (r < 96) begin
            extent = POS_W'($urandom);
        end else begin
            extent = 16'hFFFF;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            row_width = '0;
        end else if (r < 60) begin
            row_width = POS_W'($urandom_range(1, 16));
        end else if (r < 90) begin
            row_width = POS_W'($urandom_range(17, 1024));
        end else begin
            row_width = POS_W'($urandom);
        end
        send_req(op, origin, extent, row_width);
    endtask

    initial begin
        int pause_at;

        rst_n            = 1'b0;
        steady           = 1'b0;
        idle_cycles      = 0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        req_ch.valid     = 1'b0;
        req_ch.opcode    = OP_COLUMN;
        req_ch.origin    = '0;
        req_ch.extent    = '0;
        req_ch.row_width = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, first with the reset configuration.
        send_req(OP_COLUMN, 16'd0, 16'd0, 16'd1);
        send_req(OP_COLUMN, 16'hFFFF, 16'hFFFF, 16'd1);
        send_req(OP_RENDER, 16'd0, 16'hFFFF, 16'hFFFF);
        send_req(OP_ROW, 16'd1234, 16'd500, 16'd0);
        send_req(OP_NONE, 16'd7, 16'd10, 16'd3);

        drain(HOLD_OFF);
        write_reg(CFG_SPARE_LO, 24'hFFFFFF);
        write_reg(CFG_SPARE_HI, 24'h000000);
        set_config(7'd5, 24'd0, 1'b0);
        send_req(OP_COLUMN, 16'd100, 16'd3, 16'd1);
        send_req(OP_COLUMN, 16'hFFFF, 16'd17, 16'd1);
        send_req(OP_RENDER, 16'd10, 16'd2, 16'd1);
        send_req(OP_ROW, 16'd0, 16'd100, 16'd0);

        // No parts requested and no size limit: nothing comes out.
        set_config(7'd0, 24'd0, 1'b0);
        send_req(OP_COLUMN, 16'd5, 16'd10, 16'd1);
        send_req(OP_RENDER, 16'd5, 16'd10, 16'd1);

        set_config(7'd1, 24'd1, 1'b0);
        send_req(OP_COLUMN, 16'd0, 16'hFFFF, 16'd1);
        send_req(OP_ROW, 16'd300, 16'd1000, 16'd0);
        send_req(OP_ROW, 16'd300, 16'd1000, 16'hFFFF);
        send_req(OP_RENDER, 16'hFFFF, 16'd200, 16'd9);

        set_config(7'd127, 24'hFFFFFF, 1'b0);
        send_req(OP_COLUMN, 16'd1, 16'd1000, 16'd1);
        send_req(OP_RENDER, 16'd2, 16'd3, 16'd1);
        send_req(OP_ROW, 16'd9, 16'd40, 16'hFFFF);

        set_config(7'd3, 24'd10, 1'b0);
        send_req(OP_COLUMN, 16'd0, 16'd25, 16'd1);
        send_req(OP_ROW, 16'd0, 16'd25, 16'd2);
        send_req(OP_RENDER, 16'd0, 16'd25, 16'd4);

        // Random phases, each under its own configuration.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_config(7'd64, 24'd0, 1'b0);
                1: set_config(7'd0, MAX_SIZE_W'($urandom_range(1, 500)), 1'b0);
                2: set_config(7'd127, 24'hFFFFFF, 1'b1);
                3: set_config(7'd1, 24'd1, 1'b0);
                4: set_config(REQ_PARTS_W'($urandom_range(1, 64)), MAX_SIZE_W'($urandom), 1'b1);
                5: set_config(REQ_PARTS_W'($urandom_range(1, 16)),
                              MAX_SIZE_W'($urandom_range(1, 4096)), 1'b1);
                6: set_config(REQ_PARTS_W'($urandom_range(0, 127)),
                              ($urandom_range(0, 1) == 0) ? 24'd0
                                                          : MAX_SIZE_W'($urandom_range(1, 300)),
                              1'b1);
                default: set_config(REQ_PARTS_W'($urandom_range(2, 10)),
                                    MAX_SIZE_W'($urandom_range(16, 65535)), 1'b0);
            endcase
            steady   = (p == 2 || p == 5);
            pause_at = $urandom_range(8, PHASE_REQS - 8);
            for (int k = 0; k < PHASE_REQS; k++) begin
                if (k == pause_at) begin
                    drain(0);
                end
                random_req();
            end
        end
        steady = 1'b0;

        drain(HOLD_OFF);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/wrs_pkg.sv
rtl/wrs_if.sv
rtl/wrs_div.sv
rtl/wrs_front.sv
rtl/wrs_fifo.sv
rtl/wrs_back.sv
rtl/work_range_splitter.sv
bench/wrs_split_check.sv
bench/tb_top.sv
